[rtl/core/vld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vld_pkg;

   localparam int OUT_BITS        = 48;
   localparam int DEF_SAMPLE_BITS = 24;
   localparam int DEF_SUM_BITS    = 64;
   localparam int QUEUE_DEPTH     = 4;

   typedef enum logic {
      MODE_L1 = 1'b0,
      MODE_L2 = 1'b1
   } mode_type;

   localparam mode_type MODE_RESET = MODE_L2;

   typedef struct packed {
      mode_type mode;
      logic     last;
   } ctl_type;

endpackage

`default_nettype wire

[rtl/core/vld_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface vld_req_if #(
   parameter int SAMPLE_BITS = vld_pkg::DEF_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] x_value;
   logic signed [SAMPLE_BITS-1:0] y_value;
   logic                          last_element;

   modport source (output valid, x_value, y_value, last_element, input ready);
   modport sink   (input valid, x_value, y_value, last_element, output ready);
endinterface

interface vld_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [vld_pkg::OUT_BITS-1:0]  norm_value;
   logic                          saturated;

   modport source (output valid, norm_value, saturated, input ready);
   modport sink   (input valid, norm_value, saturated, output ready);
endinterface

`default_nettype wire

[rtl/core/vld_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module vld_front #(
   parameter int SAMPLE_BITS = vld_pkg::DEF_SAMPLE_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   vld_req_if.sink                      req,
   input  wire vld_pkg::mode_type       mode,
   output logic                         push_valid,
   input  wire logic                    push_ready,
   output logic [SAMPLE_BITS-1:0]       push_mag,
   output vld_pkg::ctl_type             push_ctl
);

   logic signed [SAMPLE_BITS:0] diff;
   logic [SAMPLE_BITS-1:0]      mag;
   logic                        load;

   logic                        vld_ff, vld_in;
   logic [SAMPLE_BITS-1:0]      mag_ff;
   vld_pkg::ctl_type            ctl_ff;

   // difference of two samples always fits its magnitude in SAMPLE_BITS
   assign diff = $signed({req.x_value[SAMPLE_BITS-1], req.x_value})
               - $signed({req.y_value[SAMPLE_BITS-1], req.y_value});
   assign mag  = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);

   assign req.ready = !vld_ff || push_ready;
   assign load      = req.valid && req.ready;

   always_comb begin
      vld_in = vld_ff;
      if (load) begin
         vld_in = 1'b1;
      end else if (push_ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff      <= mag;
         ctl_ff.mode <= mode;
         ctl_ff.last <= req.last_element;
      end
   end

   assign push_valid = vld_ff;
   assign push_mag   = mag_ff;
   assign push_ctl   = ctl_ff;

endmodule

`default_nettype wire

[rtl/core/vld_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module vld_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = vld_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_valid,
   output logic                  wr_ready,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  rd_valid,
   input  wire logic             rd_ready,
   output logic [WIDTH-1:0]      rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign wr_ready = cnt_ff != CNT_W'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[rtl/core/vld_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module vld_sqrt #(
   parameter int SUM_BITS = vld_pkg::DEF_SUM_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [SUM_BITS-1:0] value,
   input  wire logic                flag_in,
   output logic                     busy,
   output logic                     res_valid,
   input  wire logic                res_ready,
   output logic [((SUM_BITS + SUM_BITS % 2) / 2)-1:0] root,
   output logic                     flag_out
);

   localparam int SQ_W  = SUM_BITS + SUM_BITS % 2;
   localparam int RB    = SQ_W / 2;
   localparam int CNT_W = $clog2(RB);

   typedef enum logic [2:0] {
      SQ_IDLE = 3'b001,
      SQ_RUN  = 3'b010,
      SQ_DONE = 3'b100
   } sq_state_type;

   sq_state_type     st_ff, st_in;
   logic [SQ_W-1:0]  val_ff, val_in;
   logic [RB-1:0]    rem_ff, rem_in;
   logic [RB-1:0]    root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             flag_ff, flag_in_nx;

   logic [RB+1:0]    rem_sh;
   logic [RB+1:0]    trial;
   logic             ge;

   // one root bit per cycle, two radicand bits brought down each step
   assign rem_sh = {rem_ff, val_ff[SQ_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_comb begin
      st_in      = st_ff;
      val_in     = val_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      cnt_in     = cnt_ff;
      flag_in_nx = flag_ff;
      unique case (st_ff)
         SQ_IDLE: begin
            if (start) begin
               st_in      = SQ_RUN;
               val_in     = SQ_W'(value);
               rem_in     = '0;
               root_in    = '0;
               cnt_in     = CNT_W'(RB - 1);
               flag_in_nx = flag_in;
            end
         end
         SQ_RUN: begin
            val_in  = val_ff << 2;
            rem_in  = ge ? RB'(rem_sh - trial) : RB'(rem_sh);
            root_in = {root_ff[RB-2:0], ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               st_in = SQ_DONE;
            end
         end
         SQ_DONE: begin
            if (res_ready) begin
               st_in = SQ_IDLE;
            end
         end
         default: begin
            st_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SQ_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      flag_ff <= flag_in_nx;
   end

   assign busy      = st_ff != SQ_IDLE;
   assign res_valid = st_ff == SQ_DONE;
   assign root      = root_ff;
   assign flag_out  = flag_ff;

endmodule

`default_nettype wire

[rtl/core/vld_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module vld_back #(
   parameter int SAMPLE_BITS = vld_pkg::DEF_SAMPLE_BITS,
   parameter int SUM_BITS    = vld_pkg::DEF_SUM_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [SAMPLE_BITS-1:0] in_mag,
   input  wire vld_pkg::ctl_type       in_ctl,
   vld_rsp_if.source                   rsp
);

   localparam int TERM_W = 2 * SAMPLE_BITS;
   localparam int ADD_W  = ((SUM_BITS > TERM_W) ? SUM_BITS : TERM_W) + 1;
   localparam int OUT_W  = vld_pkg::OUT_BITS;
   localparam int CMP_W  = (SUM_BITS > OUT_W) ? SUM_BITS : OUT_W;
   localparam int RB     = (SUM_BITS + SUM_BITS % 2) / 2;

   // term stage
   logic                  t_vld_ff, t_vld_in;
   logic [TERM_W-1:0]     term_ff;
   vld_pkg::ctl_type      t_ctl_ff;
   logic [TERM_W-1:0]     term_in;
   logic                  t_load;

   // accumulator
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic                  ovf_ff, ovf_in;
   logic [ADD_W-1:0]      total;
   logic                  over;
   logic [SUM_BITS-1:0]   sum_new;
   logic                  ovf_new;
   logic                  acc_fire;
   logic                  last_ok;
   logic                  out_free;
   logic                  clip;

   // result register
   logic                  out_vld_ff, out_vld_in;
   logic [OUT_W-1:0]      out_value_ff, out_value_in;
   logic                  out_sat_ff, out_sat_in;
   logic                  out_load;

   // root unit
   logic                  sq_start;
   logic                  sq_busy;
   logic                  sq_valid;
   logic                  sq_ready;
   logic [RB-1:0]         sq_root;
   logic                  sq_flag;

   assign term_in = (in_ctl.mode == vld_pkg::MODE_L2)
                  ? TERM_W'(in_mag) * TERM_W'(in_mag)
                  : TERM_W'(in_mag);

   assign out_free = !out_vld_ff || rsp.ready;
   assign last_ok  = !sq_busy && out_free;
   assign acc_fire = t_vld_ff && (!t_ctl_ff.last || last_ok);
   assign in_ready = !t_vld_ff || acc_fire;
   assign t_load   = in_valid && in_ready;

   always_comb begin
      t_vld_in = t_vld_ff;
      if (t_load) begin
         t_vld_in = 1'b1;
      end else if (acc_fire) begin
         t_vld_in = 1'b0;
      end
   end

   // saturating add
   assign total   = ADD_W'(sum_ff) + ADD_W'(term_ff);
   assign over    = total > ADD_W'({SUM_BITS{1'b1}});
   assign sum_new = over ? {SUM_BITS{1'b1}} : total[SUM_BITS-1:0];
   assign ovf_new = ovf_ff || over;
   assign clip    = CMP_W'(sum_new) > CMP_W'({OUT_W{1'b1}});

   assign sq_start = acc_fire && t_ctl_ff.last && (t_ctl_ff.mode == vld_pkg::MODE_L2);
   assign sq_ready = out_free;

   always_comb begin
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      if (acc_fire) begin
         if (t_ctl_ff.last) begin
            sum_in = '0;
            ovf_in = 1'b0;
         end else begin
            sum_in = sum_new;
            ovf_in = ovf_new;
         end
      end
   end

   always_comb begin
      out_load     = 1'b0;
      out_value_in = out_value_ff;
      out_sat_in   = out_sat_ff;
      if (sq_valid && out_free) begin
         out_load     = 1'b1;
         out_value_in = OUT_W'(sq_root);
         out_sat_in   = sq_flag;
      end else if (acc_fire && t_ctl_ff.last && (t_ctl_ff.mode == vld_pkg::MODE_L1)) begin
         out_load     = 1'b1;
         out_value_in = clip ? {OUT_W{1'b1}} : OUT_W'(sum_new);
         out_sat_in   = ovf_new || clip;
      end
      out_vld_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff   <= 1'b0;
         sum_ff     <= '0;
         ovf_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         t_vld_ff   <= t_vld_in;
         sum_ff     <= sum_in;
         ovf_ff     <= ovf_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (t_load) begin
         term_ff  <= term_in;
         t_ctl_ff <= in_ctl;
      end
      out_value_ff <= out_value_in;
      out_sat_ff   <= out_sat_in;
   end

   vld_sqrt #(
      .SUM_BITS (SUM_BITS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .start     (sq_start),
      .value     (sum_new),
      .flag_in   (ovf_new),
      .busy      (sq_busy),
      .res_valid (sq_valid),
      .res_ready (sq_ready),
      .root      (sq_root),
      .flag_out  (sq_flag)
   );

   assign rsp.valid      = out_vld_ff;
   assign rsp.norm_value = out_value_ff;
   assign rsp.saturated  = out_sat_ff;

endmodule

`default_nettype wire

[rtl/core/vector_l1_l2_distance.sv]
// channel   dir  handshake            beat
// req_bus   in   valid / ready        x_value, y_value, last_element
// rsp_bus   out  valid / ready        norm_value, saturated
// csr       in   csr_wr_en            csr_wr_data (norm_mode)
//
// one element pair a cycle sustained, set by the front register and the
// one-multiplier term stage feeding the saturating accumulator, unless a last
// beat waits on rsp back-pressure or a busy root unit; L1 results pass the
// front, queue, term and result registers, L2 results also the bit-serial root
// unit, which holds one vector at a time while the next vector keeps accumulating
// synchronous active-high reset; no memory clearing pass
// rsp stalls back up through the 4-entry queue to req_bus.ready
`timescale 1ns / 1ps
`default_nettype none

module vector_l1_l2_distance #(
   parameter int SAMPLE_BITS = vld_pkg::DEF_SAMPLE_BITS,
   parameter int SUM_BITS    = vld_pkg::DEF_SUM_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_wr_en,
   input  wire logic  csr_wr_data,
   vld_req_if.sink    req_bus,
   vld_rsp_if.source  rsp_bus
);

   localparam int CTL_W = $bits(vld_pkg::ctl_type);
   localparam int Q_W   = SAMPLE_BITS + CTL_W;

   vld_pkg::mode_type       norm_mode_ff, norm_mode_in;

   logic                    f_valid;
   logic                    f_ready;
   logic [SAMPLE_BITS-1:0]  f_mag;
   vld_pkg::ctl_type        f_ctl;

   logic                    q_valid;
   logic                    q_ready;
   logic [Q_W-1:0]          q_data;
   vld_pkg::ctl_type        q_ctl;
   logic [SAMPLE_BITS-1:0]  q_mag;

   assign norm_mode_in = csr_wr_en ? vld_pkg::mode_type'(csr_wr_data) : norm_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_mode_ff <= vld_pkg::MODE_RESET;
      end else begin
         norm_mode_ff <= norm_mode_in;
      end
   end

   vld_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .mode       (norm_mode_ff),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_mag   (f_mag),
      .push_ctl   (f_ctl)
   );

   vld_fifo #(
      .WIDTH (Q_W),
      .DEPTH (vld_pkg::QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  ({f_ctl, f_mag}),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_data)
   );

   assign q_ctl = vld_pkg::ctl_type'(q_data[Q_W-1 -: CTL_W]);
   assign q_mag = q_data[SAMPLE_BITS-1:0];

   vld_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (q_valid),
      .in_ready (q_ready),
      .in_mag   (q_mag),
      .in_ctl   (q_ctl),
      .rsp      (rsp_bus)
   );

endmodule

`default_nettype wire

[rtl/core/vld_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module vld_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         csr_wr_en,
   input wire logic                         csr_wr_data,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_last,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [vld_pkg::OUT_BITS-1:0] rsp_norm_value,
   input wire logic                         rsp_saturated
);

   logic [7:0]        pending_ff, pending_in;
   vld_pkg::mode_type mode_ff;
   logic              last_beat;
   logic              rsp_beat;

   assign last_beat = req_valid && req_ready && req_last;
   assign rsp_beat  = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (last_beat && !rsp_beat) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_beat && !last_beat) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         mode_ff    <= vld_pkg::MODE_RESET;
      end else begin
         pending_ff <= pending_in;
         if (csr_wr_en) begin
            mode_ff <= vld_pkg::mode_type'(csr_wr_data);
         end
      end
   end

   // no result left over from before reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_norm_value)
                                  && $stable(rsp_saturated))
      else $error("stalled result changed");

   // every result answers an earlier last beat
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result without a pending last element");

   // a root never exceeds 32 bits
   a_root_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (mode_ff == vld_pkg::MODE_L2) |-> rsp_norm_value[47:32] == 16'd0)
      else $error("root result too wide");

endmodule

bind vector_l1_l2_distance vld_checker u_vld_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_wr_en      (csr_wr_en),
   .csr_wr_data    (csr_wr_data),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_last       (req_bus.last_element),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_norm_value (rsp_bus.norm_value),
   .rsp_saturated  (rsp_bus.saturated)
);

`default_nettype wire

[sim/tb_vector_l1_l2_distance.sv]
`timescale 1ns / 1ps

module tb_vector_l1_l2_distance;

   localparam int SAMPLE_BITS    = vld_pkg::DEF_SAMPLE_BITS;
   localparam int SUM_BITS       = vld_pkg::DEF_SUM_BITS;
   localparam int CLOCK_PERIOD   = 8;
   localparam int SETTLE_CYCLES  = 4 + SUM_BITS / 2 + 12;
   localparam int TIMEOUT_CYCLES = 600_000;
   localparam int RANDOM_ITEMS   = 560;
   localparam int HOLD_CYCLES    = 300;
   localparam int LONG_ITEMS     = 24;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [63:0]            NORM_MAX   = (64'd1 << vld_pkg::OUT_BITS) - 64'd1;

   typedef struct {
      logic [vld_pkg::OUT_BITS-1:0] norm_value;
      logic                         saturated;
   } norm_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   vld_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   vld_rsp_if rsp_bus ();

   vector_l1_l2_distance #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .SUM_BITS   (SUM_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus)
   );

   // distance predictor state
   vld_pkg::mode_type norm_sel;
   logic [63:0]       dist_sum;
   logic              dist_clipped;
   norm_result_type   expected_norms[$];

   int  error_count;
   int  beats_sent;
   int  vectors_l1;
   int  vectors_l2;
   int  results_checked;
   int  results_saturated;
   int  stall_left;
   int  hold_count;
   bit  idle_on;
   bit  stall_on;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout with %0d results outstanding", expected_norms.size());
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
   endtask

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] probe;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         probe = root | (64'd1 << i);
         if (probe * probe <= v)
            root = probe;
      end
      return root;
   endfunction

   task automatic predict_distance(input logic [SAMPLE_BITS-1:0] x, input logic [SAMPLE_BITS-1:0] y,
                                   input logic last);
      logic [SAMPLE_BITS:0] diff;
      logic [SAMPLE_BITS:0] abs_diff;
      logic [63:0]          mag;
      logic [63:0]          term;
      logic [64:0]          total;
      logic [63:0]          outv;
      norm_result_type      res;
      diff     = {x[SAMPLE_BITS-1], x} - {y[SAMPLE_BITS-1], y};
      abs_diff = diff[SAMPLE_BITS] ? -diff : diff;
      mag      = 64'(abs_diff);
      term     = (norm_sel == vld_pkg::MODE_L2) ? mag * mag : mag;
      total    = {1'b0, dist_sum} + {1'b0, term};
      if (total[64]) begin
         dist_sum     = '1;
         dist_clipped = 1'b1;
      end else begin
         dist_sum = total[63:0];
      end
      if (last) begin
         outv = (norm_sel == vld_pkg::MODE_L2) ? floor_root(dist_sum) : dist_sum;
         if (outv > NORM_MAX) begin
            outv         = NORM_MAX;
            dist_clipped = 1'b1;
         end
         res.norm_value = outv[vld_pkg::OUT_BITS-1:0];
         res.saturated  = dist_clipped;
         expected_norms.push_back(res);
         if (norm_sel == vld_pkg::MODE_L2)
            vectors_l2++;
         else
            vectors_l1++;
         dist_sum     = '0;
         dist_clipped = 1'b0;
      end
   endtask

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_element(input logic [SAMPLE_BITS-1:0] x, input logic [SAMPLE_BITS-1:0] y,
                               input logic last, input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.x_value      <= x;
      req_bus.y_value      <= y;
      req_bus.last_element <= last;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      predict_distance(x, y, last);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expected_norms.size() != 0);
   endtask

   task automatic write_mode(input vld_pkg::mode_type m);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= logic'(m);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      norm_sel = m;
   endtask

   function automatic int draw_gap();
      return idle_on ? $urandom_range(0, 6) : 0;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] draw_sample(input int kind);
      logic [SAMPLE_BITS-1:0] v;
      case (kind)
         0: v = SAMPLE_BITS'($urandom);
         1: begin
            v = SAMPLE_BITS'($urandom_range(0, 8191));
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
         default: begin
            case ($urandom_range(0, 3))
               0: v = SAMPLE_MAX;
               1: v = SAMPLE_MIN;
               2: v = '0;
               default: v = '1;
            endcase
         end
      endcase
      return v;
   endfunction

   // rsp ready: long hold first, then the per-result stall
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_count > 0) begin
            hold_count--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      norm_result_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         if (rsp_bus.saturated)
            results_saturated++;
         if (expected_norms.size() == 0) begin
            report_mismatch("beat with no result outstanding", 64'(rsp_bus.norm_value), 64'd0);
         end else begin
            want = expected_norms.pop_front();
            if (rsp_bus.norm_value !== want.norm_value)
               report_mismatch("norm_value", 64'(rsp_bus.norm_value), 64'(want.norm_value));
            if (rsp_bus.saturated !== want.saturated)
               report_mismatch("saturated", 64'(rsp_bus.saturated), 64'(want.saturated));
         end
         stall_left = stall_on ? $urandom_range(0, 6) : 0;
      end
   end

   task automatic test_reset_mode_l2();
      send_element(SAMPLE_MAX, SAMPLE_MIN, 1'b1, draw_gap());
      send_element(SAMPLE_MIN, SAMPLE_MAX, 1'b1, draw_gap());
      send_element('0, '0, 1'b1, draw_gap());
      send_element('1, '0, 1'b1, draw_gap());
      send_element(SAMPLE_BITS'(3 << 12), '0, 1'b0, draw_gap());
      send_element(SAMPLE_BITS'(4 << 12), '0, 1'b1, draw_gap());
      send_element(SAMPLE_BITS'(24'h555555), SAMPLE_BITS'(24'hAAAAAA), 1'b1, draw_gap());
   endtask

   task automatic test_l1_extremes();
      write_mode(vld_pkg::MODE_L1);
      send_element(SAMPLE_MAX, SAMPLE_MIN, 1'b1, draw_gap());
      send_element(SAMPLE_MIN, SAMPLE_MAX, 1'b0, draw_gap());
      send_element(SAMPLE_MAX, SAMPLE_MIN, 1'b1, draw_gap());
      send_element('0, '0, 1'b1, draw_gap());
      send_element(SAMPLE_BITS'(24'hAAAAAA), SAMPLE_BITS'(24'h555555), 1'b1, draw_gap());
      send_element(SAMPLE_MIN, '1, 1'b0, draw_gap());
      send_element('1, SAMPLE_MIN, 1'b1, draw_gap());
   endtask

   // mode is written between beats of one vector
   task automatic test_mode_switch_in_vector();
      write_mode(vld_pkg::MODE_L2);
      send_element(SAMPLE_MAX, SAMPLE_MIN, 1'b0, draw_gap());
      send_element(SAMPLE_MIN, SAMPLE_MAX, 1'b0, draw_gap());
      write_mode(vld_pkg::MODE_L1);
      send_element(SAMPLE_MAX, '0, 1'b1, draw_gap());
      send_element(SAMPLE_BITS'(24'h012345), SAMPLE_MIN, 1'b0, draw_gap());
      send_element(SAMPLE_MAX, SAMPLE_MIN, 1'b0, draw_gap());
      write_mode(vld_pkg::MODE_L2);
      send_element(SAMPLE_BITS'(1), '0, 1'b1, draw_gap());
   endtask

   // one long vector of full-scale differences, beats back to back, then a one-beat vector
   task automatic test_long_vector();
      bit saved_idle;
      saved_idle = idle_on;
      idle_on    = 1'b0;
      write_mode(vld_pkg::MODE_L2);
      for (int k = 0; k < LONG_ITEMS; k++)
         send_element(SAMPLE_MAX, SAMPLE_MIN, k == LONG_ITEMS - 1, 0);
      send_element(SAMPLE_BITS'(5), '0, 1'b1, 0);
      idle_on = saved_idle;
      drain_results();
   endtask

   task automatic test_backpressure();
      write_mode(vld_pkg::MODE_L2);
      hold_count = HOLD_CYCLES;
      for (int k = 0; k < 40; k++)
         send_element(draw_sample(0), draw_sample(0), 1'b1, 0);
      drain_results();
   endtask

   task automatic test_random_vectors(input int n_items);
      int                sent;
      int                phase;
      int                in_phase;
      int                len;
      int                kind;
      vld_pkg::mode_type m;
      sent  = 0;
      phase = 0;
      while (sent < n_items) begin
         if (phase < 2)
            m = (phase == 0) ? vld_pkg::MODE_L1 : vld_pkg::MODE_L2;
         else
            m = vld_pkg::mode_type'($urandom_range(0, 1));
         write_mode(m);
         idle_on  = (phase % 3) != 2;
         stall_on = (phase % 3) != 2;
         in_phase = 0;
         while (in_phase < 100 && sent < n_items) begin
            len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 8);
            kind = $urandom_range(0, 5);
            if (kind > 2)
               kind = 0;
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0)
                  send_element(draw_sample(kind), '0, k == len - 1, draw_gap());
               else
                  send_element(draw_sample(kind), draw_sample(kind), k == len - 1, draw_gap());
            end
            in_phase += len;
            sent     += len;
            if ($urandom_range(0, 19) == 0)
               drain_results();
         end
         phase++;
      end
      idle_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.x_value      = '0;
      req_bus.y_value      = '0;
      req_bus.last_element = 1'b0;
      norm_sel             = vld_pkg::MODE_RESET;
      dist_sum             = '0;
      dist_clipped         = 1'b0;
      error_count          = 0;
      beats_sent           = 0;
      vectors_l1           = 0;
      vectors_l2           = 0;
      results_checked      = 0;
      results_saturated    = 0;
      stall_left           = 0;
      hold_count           = 0;
      idle_on              = 1'b1;
      stall_on             = 1'b1;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_mode_l2();
      test_l1_extremes();
      test_mode_switch_in_vector();
      test_backpressure();
      test_random_vectors(RANDOM_ITEMS);
      test_long_vector();

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("sent %0d element beats: %0d L1 vectors and %0d L2 vectors", beats_sent,
               vectors_l1, vectors_l2);
      $display("checked %0d results, %0d flagged saturated, %0d mismatches", results_checked,
               results_saturated, error_count);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
